// File: hdl/srlm_pkg.sv
package srlm_pkg;

   localparam int ENTRIES     = 256;
   localparam int LIST_IDS    = 1024;
   localparam int LIST_W      = 10;
   localparam int ADDR_W      = 32;
   localparam int LEN_W       = 6;
   localparam int FUNC_W      = 2;
   localparam int MAX_LEN     = 32;
   localparam int LIST_IDX_W  = $clog2(LIST_IDS);

   localparam logic [FUNC_W-1:0] OP_ADD     = 2'd0;
   localparam logic [FUNC_W-1:0] OP_DISABLE = 2'd1;
   localparam logic [FUNC_W-1:0] OP_QUERY   = 2'd2;

   // Operation carried along the cell chain.
   localparam logic [1:0] CMD_NONE    = 2'd0;
   localparam logic [1:0] CMD_ADD     = 2'd1;
   localparam logic [1:0] CMD_DISABLE = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   typedef struct packed {
      logic [1:0]        cmd;
      logic              pass2;
      logic [LIST_W-1:0] list;
      logic [ADDR_W-1:0] addr;
      logic [LEN_W-1:0]  len;
      logic              claimed;
      logic              dup;
   } token_type;

   typedef struct packed {
      logic              lookup;
      logic [LIST_W-1:0] list;
   } map_req_type;

   function automatic logic [ADDR_W-1:0] len_mask(input logic [LEN_W-1:0] len);
      logic [ADDR_W-1:0] m;
      m = '0;
      for (int i = 0; i < ADDR_W; i++) begin
         if (len > LEN_W'(i)) begin
            m[ADDR_W-1-i] = 1'b1;
         end
      end
      return m;
   endfunction

endpackage

// File: hdl/srlm_stream_if.sv
interface srlm_stream_if #(parameter int W = 1);
   logic         valid;
   logic         ready;
   logic [W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// File: hdl/srlm_ram.sv
module srlm_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// File: hdl/srlm_cell.sv
// One rule slot. The token moves one cell per cycle.
module srlm_cell (
   input  logic                         clock,
   input  logic                         reset,
   input  srlm_pkg::token_type          tok_in,
   output srlm_pkg::map_req_type        map_req,
   output srlm_pkg::token_type          tok_out
);
   logic                            valid_ff, valid_in;
   logic [srlm_pkg::LIST_W-1:0]     list_ff, list_in;
   logic [srlm_pkg::ADDR_W-1:0]     prefix_ff, prefix_in;
   logic [srlm_pkg::LEN_W-1:0]      len_ff, len_in;
   srlm_pkg::token_type             tok_ff, tok_in_n;
   logic [srlm_pkg::ADDR_W-1:0]     m;
   logic                            addr_hit;

   always_comb begin
      m        = srlm_pkg::len_mask(len_ff);
      addr_hit = valid_ff && ((tok_in.addr & m) == prefix_ff);
      valid_in  = valid_ff;
      list_in   = list_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;
      tok_in_n  = tok_in;
      map_req.lookup = 1'b0;
      map_req.list   = list_ff;
      case (tok_in.cmd)
         srlm_pkg::CMD_ADD: begin
            if (valid_ff && list_ff == tok_in.list && len_ff == tok_in.len &&
                prefix_ff == tok_in.addr) begin
               tok_in_n.dup = 1'b1;
            end
            if (!valid_ff && !tok_in.claimed) begin
               tok_in_n.claimed = 1'b1;
            end
         end
         srlm_pkg::CMD_DISABLE: begin
            if (valid_ff && list_ff == tok_in.list) begin
               valid_in = 1'b0;
            end
         end
         srlm_pkg::CMD_QUERY: begin
            map_req.lookup = addr_hit;
         end
         default: begin
         end
      endcase
   end

   // Second add pass: store in the claimed slot when no duplicate was found.
   logic commit;
   assign commit = tok_in.cmd == srlm_pkg::CMD_ADD && tok_in.pass2 && !tok_in.dup &&
                   !valid_ff && !tok_in.claimed;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         tok_ff   <= '0;
      end else begin
         valid_ff <= commit ? 1'b1 : valid_in;
         tok_ff   <= tok_in_n;
      end
      if (commit) begin
         list_ff   <= tok_in.list;
         prefix_ff <= tok_in.addr;
         len_ff    <= tok_in.len;
      end else begin
         list_ff   <= list_in;
         prefix_ff <= prefix_in;
         len_ff    <= len_in;
      end
   end

   assign tok_out = tok_ff;
endmodule

// File: hdl/subnet_rule_list_match_top.sv
// Subnet rule list matcher. Each request transaction carries an operation
// (add subnet, disable list, query address pair) and yields one response
// transaction with a verdict and a status bit. The rules live in a chain of
// ENTRIES cells; a token enters the head of the chain and moves one cell per
// cycle, and an add, a disable or a query walks the chain twice. An add first
// looks for a duplicate and a free slot and then, if it found no duplicate,
// stores in the lowest free slot; a disable clears matching cells; a query
// first marks, in a list-id memory, the lists that match the source, and then
// checks destination matches against those marks. The chain length sets the
// timing. The second walk ends only after the final mark read has returned.
// A query clears the mark memory before its first walk. The unused opcode
// is answered in the cycle after acceptance. The block is ready for the
// next request in the cycle after its response is taken. After reset the
// block clears the mark memory before it accepts a request.
// One transaction is in flight at a time; the response is held in an output
// register until taken.
module subnet_rule_list_match_top (
   input  logic clock,
   input  logic reset,
   srlm_stream_if.sink   req_chan,
   srlm_stream_if.source rsp_chan
);
   localparam logic [2:0] ST_CLEAR = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_RUN1  = 3'd2;
   localparam logic [2:0] ST_RUN2  = 3'd3;
   localparam logic [2:0] ST_RESP  = 3'd4;
   localparam int CNT_W = $clog2(srlm_pkg::LIST_IDS + srlm_pkg::ENTRIES + 4) + 1;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   srlm_pkg::token_type tok_ff, tok_in;
   logic             verdict_ff, verdict_in, status_ff, status_in;

   // Request fields.
   logic [1:0]                     req_func;
   logic [srlm_pkg::LIST_W-1:0]    req_list_id;
   logic [srlm_pkg::ADDR_W-1:0]    req_addr_a, req_addr_b;
   logic [srlm_pkg::LEN_W-1:0]     req_prefix_len, sat_len;
   assign {req_func, req_list_id, req_addr_a, req_addr_b, req_prefix_len} = req_chan.data;
   assign sat_len = (req_prefix_len > srlm_pkg::LEN_W'(srlm_pkg::MAX_LEN)) ?
                    srlm_pkg::LEN_W'(srlm_pkg::MAX_LEN) : req_prefix_len;

   logic [srlm_pkg::ADDR_W-1:0] dst_ff;

   // Chain.
   srlm_pkg::token_type   link [srlm_pkg::ENTRIES+1];
   srlm_pkg::map_req_type mreq [srlm_pkg::ENTRIES];
   logic                  inject;

   // Mark memory: pass 1 writes, pass 2 reads. Only one cell's request is
   // active per cycle because only one token is in the chain.
   logic                          mem_we;
   logic [srlm_pkg::LIST_IDX_W-1:0] mem_wa, mem_ra;
   logic                          mem_wd, mem_rd;
   logic                          any_lookup;
   logic [srlm_pkg::LIST_W-1:0]   look_list;
   logic                          look_pending_ff;

   always_comb begin
      any_lookup = 1'b0;
      look_list  = '0;
      for (int i = 0; i < srlm_pkg::ENTRIES; i++) begin
         if (mreq[i].lookup) begin
            any_lookup = 1'b1;
            look_list  = mreq[i].list;
         end
      end
   end

   // In pass 2 a cell whose subnet matches the destination asks for the
   // mark of its list. The memory answers in the next cycle, and the hit is
   // collected here rather than in the cell.
   logic pass2_hit_ff;

   srlm_ram #(.WIDTH(1), .DEPTH(srlm_pkg::LIST_IDS)) u_marks (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_wa),
      .wr_data (mem_wd),
      .rd_addr (mem_ra),
      .rd_data (mem_rd)
   );

   assign mem_ra = srlm_pkg::LIST_IDX_W'(look_list);
   always_comb begin
      mem_we = 1'b0;
      mem_wa = srlm_pkg::LIST_IDX_W'(look_list);
      mem_wd = 1'b1;
      if (state_ff == ST_CLEAR ||
          (state_ff == ST_RUN1 && cnt_ff != '0 && tok_ff.cmd == srlm_pkg::CMD_QUERY &&
           !tok_ff.pass2 && cnt_ff <= CNT_W'(srlm_pkg::LIST_IDS))) begin
         mem_we = 1'b1;
         mem_wa = srlm_pkg::LIST_IDX_W'(cnt_ff - 1'b1);
         mem_wd = 1'b0;
      end else if (any_lookup && !link[0].pass2 && state_ff == ST_RUN1) begin
         mem_we = 1'b1;
      end
   end

   // A lookup issued in pass 2 returns its mark in the next cycle; a set
   // mark with a destination match means forward.
   always_ff @(posedge clock) begin
      if (reset) begin
         look_pending_ff <= 1'b0;
         pass2_hit_ff    <= 1'b0;
      end else begin
         look_pending_ff <= any_lookup && state_ff == ST_RUN2;
         if (state_ff == ST_IDLE) begin
            pass2_hit_ff <= 1'b0;
         end else if (look_pending_ff && mem_rd) begin
            pass2_hit_ff <= 1'b1;
         end
      end
   end

   for (genvar g = 0; g < srlm_pkg::ENTRIES; g++) begin : g_cell
      srlm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .tok_in  (link[g]),
         .map_req (mreq[g]),
         .tok_out (link[g+1])
      );
   end

   assign link[0] = inject ? tok_ff : '0;

   // Token injection: at the start of each pass the token enters cell 0.
   localparam int CLR = srlm_pkg::LIST_IDS;
   always_comb begin
      inject = 1'b0;
      if (state_ff == ST_RUN1 && cnt_ff == CNT_W'(CLR + 1)) inject = 1'b1;
      if (state_ff == ST_RUN2 && cnt_ff == '0) inject = 1'b1;
   end

   assign req_chan.ready = state_ff == ST_IDLE;
   assign rsp_chan.valid = state_ff == ST_RESP;
   assign rsp_chan.data  = {verdict_ff, status_ff};

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      tok_in     = tok_ff;
      verdict_in = verdict_ff;
      status_in  = status_ff;
      case (state_ff)
         ST_CLEAR: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CLR)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_chan.valid) begin
               tok_in         = '0;
               tok_in.list    = req_list_id;
               tok_in.len     = sat_len;
               tok_in.addr    = req_addr_a & srlm_pkg::len_mask(sat_len);
               verdict_in     = 1'b0;
               status_in      = 1'b0;
               cnt_in         = CNT_W'(CLR + 1);
               state_in       = ST_RUN1;
               case (req_func)
                  srlm_pkg::OP_ADD:     tok_in.cmd = srlm_pkg::CMD_ADD;
                  srlm_pkg::OP_DISABLE: tok_in.cmd = srlm_pkg::CMD_DISABLE;
                  srlm_pkg::OP_QUERY: begin
                     tok_in.cmd  = srlm_pkg::CMD_QUERY;
                     tok_in.addr = req_addr_a;
                     cnt_in      = CNT_W'(1);
                  end
                  default: state_in = ST_RESP;
               endcase
            end
         end
         ST_RUN1: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CLR + 1 + srlm_pkg::ENTRIES)) begin
               // The first walk has left the chain. An add that found no
               // duplicate and no free slot is dropped, as is one that found a
               // duplicate; otherwise the second walk stores it in the lowest free slot.
               tok_in         = link[srlm_pkg::ENTRIES];
               tok_in.pass2   = 1'b1;
               tok_in.claimed = 1'b0;
               status_in      = tok_ff.cmd == srlm_pkg::CMD_ADD &&
                                !link[srlm_pkg::ENTRIES].dup &&
                                !link[srlm_pkg::ENTRIES].claimed;
               if (tok_ff.cmd == srlm_pkg::CMD_QUERY) tok_in.addr = dst_ff;
               cnt_in   = '0;
               state_in = ST_RUN2;
            end
         end
         ST_RUN2: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(srlm_pkg::ENTRIES + 2)) begin
               if (tok_ff.cmd == srlm_pkg::CMD_QUERY) verdict_in = pass2_hit_ff;
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (rsp_chan.ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= (state_ff == ST_CLEAR && cnt_ff == '0) ? CNT_W'(1) : cnt_in;
      end
      tok_ff     <= tok_in;
      verdict_ff <= verdict_in;
      status_ff  <= status_in;
      if (state_ff == ST_IDLE && req_chan.valid) dst_ff <= req_addr_b;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid |-> !req_chan.ready)
      else $error("request taken while response pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.ready) |=> $stable(rsp_chan.data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |=> !req_chan.ready)
      else $error("second request accepted");
endmodule

// File: sim/srlm_tb_pkg.sv
`timescale 1ns / 1ps

// Shared types for the rule table bench: one request item and one response item.
package srlm_tb_pkg;

   localparam int REQ_W = srlm_pkg::FUNC_W + srlm_pkg::LIST_W + 2 * srlm_pkg::ADDR_W +
                          srlm_pkg::LEN_W;
   localparam int RSP_W = 2;
   localparam logic [srlm_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

   typedef struct packed {
      logic [srlm_pkg::FUNC_W-1:0] func;
      logic [srlm_pkg::LIST_W-1:0] list_id;
      logic [srlm_pkg::ADDR_W-1:0] addr_a;
      logic [srlm_pkg::ADDR_W-1:0] addr_b;
      logic [srlm_pkg::LEN_W-1:0]  prefix_len;
   } rule_req_type;

   typedef struct packed {
      logic verdict;
      logic status;
   } rule_rsp_type;

endpackage

// File: sim/subnet_rule_list_match_top_tb.sv
`timescale 1ns / 1ps

// Bench for the subnet rule list matcher. Requests are queued up front by an
// initial block, a clocked driver offers them with random idle bursts, and a
// clocked monitor takes responses with its own random stalls. Every accepted
// request transaction runs through the bench's own rule table model and the
// predicted response is queued for the monitor to compare against.
module subnet_rule_list_match_top_tb;

   localparam int TOTAL_ITEMS   = 1170;
   localparam int QUIET_TAIL    = 120;
   localparam int LONG_HOLD     = 4000;
   localparam int HOLD_AT_RSP   = 40;
   localparam int DRAIN_CYCLES  = 2000;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   srlm_stream_if #(.W(srlm_tb_pkg::REQ_W)) req_if ();
   srlm_stream_if #(.W(srlm_tb_pkg::RSP_W)) rsp_if ();

   subnet_rule_list_match_top uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if.sink),
      .rsp_chan (rsp_if.source)
   );

   // Pending stimulus. A set drain flag makes the driver wait until every
   // expected response has been received before offering that item.
   typedef struct {
      srlm_tb_pkg::rule_req_type req;
      bit                        drain_first;
   } pending_type;

   pending_type               pending_q[$];
   srlm_tb_pkg::rule_rsp_type verdict_q[$];
   bit        stimulus_done = 1'b0;
   int        errors = 0;
   int        sent = 0;
   int        received = 0;
   int        n_adds = 0, n_full = 0, n_fwd = 0, n_deny = 0;

   // Rule table model, sized from the package.
   bit                          entry_valid [srlm_pkg::ENTRIES];
   logic [srlm_pkg::LIST_W-1:0] entry_list  [srlm_pkg::ENTRIES];
   logic [srlm_pkg::ADDR_W-1:0] entry_net   [srlm_pkg::ENTRIES];
   logic [srlm_pkg::LEN_W-1:0]  entry_len   [srlm_pkg::ENTRIES];

   function automatic logic [srlm_pkg::ADDR_W-1:0] prefix_mask(int unsigned n);
      if (n == 0) return '0;
      return ~32'h0 << (32 - n);
   endfunction

   function automatic bit net_hits(int slot, logic [srlm_pkg::ADDR_W-1:0] addr);
      logic [srlm_pkg::ADDR_W-1:0] m;
      m = prefix_mask(entry_len[slot]);
      return (addr & m) == (entry_net[slot] & m);
   endfunction

   // Applies one request to the model table and returns the response.
   function automatic srlm_tb_pkg::rule_rsp_type apply_rule_op(srlm_tb_pkg::rule_req_type r);
      srlm_tb_pkg::rule_rsp_type   rsp;
      int unsigned                 plen;
      logic [srlm_pkg::ADDR_W-1:0] net;
      int                          free_slot;
      bit                          dup;
      bit                          src_marks [srlm_pkg::LIST_IDS];
      rsp = '0;
      free_slot = -1;
      dup = 1'b0;
      case (r.func)
         srlm_pkg::OP_ADD: begin
            plen = (r.prefix_len > srlm_pkg::MAX_LEN) ? srlm_pkg::MAX_LEN : r.prefix_len;
            net = r.addr_a & prefix_mask(plen);
            for (int i = 0; i < srlm_pkg::ENTRIES; i++) begin
               if (entry_valid[i]) begin
                  if (entry_list[i] == r.list_id && entry_len[i] == plen &&
                      entry_net[i] == net) dup = 1'b1;
               end else if (free_slot < 0) begin
                  free_slot = i;
               end
            end
            if (!dup) begin
               if (free_slot < 0) begin
                  rsp.status = 1'b1;
               end else begin
                  entry_valid[free_slot] = 1'b1;
                  entry_list[free_slot]  = r.list_id;
                  entry_net[free_slot]   = net;
                  entry_len[free_slot]   = srlm_pkg::LEN_W'(plen);
               end
            end
         end
         srlm_pkg::OP_DISABLE: begin
            for (int i = 0; i < srlm_pkg::ENTRIES; i++)
               if (entry_valid[i] && entry_list[i] == r.list_id) entry_valid[i] = 1'b0;
         end
         srlm_pkg::OP_QUERY: begin
            for (int i = 0; i < srlm_pkg::ENTRIES; i++)
               if (entry_valid[i] && net_hits(i, r.addr_a)) src_marks[entry_list[i]] = 1'b1;
            for (int i = 0; i < srlm_pkg::ENTRIES; i++)
               if (entry_valid[i] && src_marks[entry_list[i]] && net_hits(i, r.addr_b))
                  rsp.verdict = 1'b1;
         end
         default: ;
      endcase
      return rsp;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus generation. Subnets that were added are remembered so that
   // queries can be aimed inside them; lists that received adds are
   // remembered so that the table can be emptied before the fill test.
   // ---------------------------------------------------------------------
   logic [srlm_pkg::ADDR_W-1:0] known_net [$];
   logic [srlm_pkg::LEN_W-1:0]  known_len [$];
   bit                          list_used [srlm_pkg::LIST_IDS];

   task automatic queue_item(logic [srlm_pkg::FUNC_W-1:0] f, logic [srlm_pkg::LIST_W-1:0] l,
                             logic [srlm_pkg::ADDR_W-1:0] a, logic [srlm_pkg::ADDR_W-1:0] b,
                             logic [srlm_pkg::LEN_W-1:0] n, bit drain = 1'b0);
      pending_type p;
      p.req = '{func: f, list_id: l, addr_a: a, addr_b: b, prefix_len: n};
      p.drain_first = drain;
      if (f == srlm_pkg::OP_ADD) begin
         list_used[l] = 1'b1;
         known_net = {known_net, a};
         known_len = {known_len, n};
      end
      pending_q = {pending_q, p};
   endtask

   // An address inside a remembered subnet, with random host bits.
   function automatic logic [srlm_pkg::ADDR_W-1:0] aimed_addr();
      int k;
      logic [srlm_pkg::ADDR_W-1:0] m;
      if (known_net.size() == 0) return $urandom;
      k = $urandom_range(known_net.size() - 1);
      m = prefix_mask(known_len[k] > srlm_pkg::MAX_LEN ? srlm_pkg::MAX_LEN : known_len[k]);
      return (known_net[k] & m) | ($urandom & ~m);
   endfunction

   // One random item: mostly adds and queries on a handful of busy lists,
   // with queries aimed at stored subnets, plus disables and noise.
   task automatic queue_random_item();
      int unsigned pick;
      logic [srlm_pkg::LIST_W-1:0] l;
      pick = $urandom_range(99);
      l = ($urandom_range(9) == 0) ? srlm_pkg::LIST_W'($urandom) :
                                     srlm_pkg::LIST_W'($urandom_range(15));
      if (pick < 35) begin
         if ($urandom_range(3) == 0)
            queue_item(srlm_pkg::OP_ADD, l, aimed_addr(), $urandom,
                       srlm_pkg::LEN_W'($urandom));
         else
            queue_item(srlm_pkg::OP_ADD, l, $urandom, $urandom,
                       srlm_pkg::LEN_W'($urandom_range(32)));
      end else if (pick < 85) begin
         queue_item(srlm_pkg::OP_QUERY, l,
                    $urandom_range(4) ? aimed_addr() : $urandom,
                    $urandom_range(4) ? aimed_addr() : $urandom,
                    srlm_pkg::LEN_W'($urandom));
      end else if (pick < 95) begin
         queue_item(srlm_pkg::OP_DISABLE, l, $urandom, $urandom, srlm_pkg::LEN_W'($urandom));
      end else begin
         queue_item(srlm_tb_pkg::OP_UNUSED, srlm_pkg::LIST_W'($urandom), $urandom, $urandom,
                    srlm_pkg::LEN_W'($urandom));
      end
   endtask

   initial begin
      int base;
      // Directed opening: a default route, a host route, over-long prefix
      // lengths, a duplicate add, the highest list id, the unused opcode and
      // a disable of a list that holds nothing.
      queue_item(srlm_pkg::OP_QUERY, 0, 32'h0, 32'hFFFF_FFFF, 0);
      queue_item(srlm_pkg::OP_ADD, 1, 32'hC0A8_0101, 0, 32);
      queue_item(srlm_pkg::OP_ADD, 1, 32'h0A00_0000, 32'hFFFF_FFFF, 8);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hC0A8_0101, 32'h0A12_3456, 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hC0A8_0100, 32'h0A12_3456, 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'h0A12_3456, 32'hC0A8_0101, 0);
      queue_item(srlm_pkg::OP_ADD, 1, 32'hC0A8_0101, 0, 32);
      queue_item(srlm_pkg::OP_ADD, 1, 32'hC0A8_01FF, 0, 63);
      queue_item(srlm_pkg::OP_ADD, 1, 32'hC0A8_0101, 0, 33);
      queue_item(srlm_pkg::OP_ADD, 1023, 32'h0, 0, 0);
      queue_item(srlm_pkg::OP_ADD, 1023, 32'hFFFF_FFFF, 32'h0, 32);
      queue_item(srlm_pkg::OP_QUERY, 1023, 32'h1234_5678, 32'hFFFF_FFFF, 63);
      queue_item(srlm_pkg::OP_QUERY, 1023, 32'h1234_5678, 32'hFFFF_FFFE, 0);
      queue_item(srlm_pkg::OP_ADD, 512, 32'hAC10_0000, 0, 12);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hAC1F_FFFF, 32'hAC10_0001, 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hAC20_0000, 32'hAC10_0001, 0);
      queue_item(srlm_tb_pkg::OP_UNUSED, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63);
      queue_item(srlm_pkg::OP_DISABLE, 777, 32'h0, 32'h0, 0);
      queue_item(srlm_pkg::OP_DISABLE, 1023, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 63);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
      queue_item(srlm_pkg::OP_DISABLE, 1, 0, 0, 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'hC0A8_0101, 32'h0A12_3456, 0);

      repeat (400) queue_random_item();

      // Empty the table, then add distinct host routes until it overflows.
      for (int l = 0; l < srlm_pkg::LIST_IDS; l++)
         if (list_used[l])
            queue_item(srlm_pkg::OP_DISABLE, srlm_pkg::LIST_W'(l), $urandom, $urandom, 0);
      base = $urandom;
      for (int i = 0; i < srlm_pkg::ENTRIES + 6; i++)
         queue_item(srlm_pkg::OP_ADD, 5, 32'(base + i), $urandom, 32);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'(base), 32'(base + srlm_pkg::ENTRIES - 1), 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'(base), 32'(base + srlm_pkg::ENTRIES + 3), 0);
      queue_item(srlm_pkg::OP_DISABLE, 5, 0, 0, 0);
      queue_item(srlm_pkg::OP_QUERY, 0, 32'(base), 32'(base + 1), 0);

      // The next item is held back until every response has come in.
      queue_item(srlm_pkg::OP_QUERY, 0, $urandom, $urandom, 0, 1'b1);
      while (pending_q.size() < TOTAL_ITEMS) queue_random_item();
      stimulus_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Driver. At each rising edge it retires an accepted transaction into
   // the model, then decides once what to offer next, so valid never sees
   // two nonblocking updates in one time step.
   // ---------------------------------------------------------------------
   int  idle_left = 0;
   logic                      next_valid;
   srlm_tb_pkg::rule_req_type next_data;

   initial begin
      req_if.valid = 1'b0;
      req_if.data  = '0;
      rsp_if.ready = 1'b0;
   end

   always @(posedge clock) begin
      next_valid = req_if.valid;
      next_data  = req_if.data;
      if (reset) begin
         next_valid = 1'b0;
      end else begin
         if (req_if.valid && req_if.ready) begin
            srlm_tb_pkg::rule_req_type r;
            srlm_tb_pkg::rule_rsp_type x;
            r = req_if.data;
            x = apply_rule_op(r);
            verdict_q = {verdict_q, x};
            if (r.func == srlm_pkg::OP_ADD) n_adds++;
            if (x.status) n_full++;
            if (r.func == srlm_pkg::OP_QUERY) begin
               if (x.verdict) n_fwd++;
               else n_deny++;
            end
            void'(pending_q.pop_front());
            sent++;
            next_valid = 1'b0;
            // A random idle burst may follow, but never near the end.
            if (sent < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(3) == 0)
               idle_left = $urandom_range(1, 12);
         end
         if (!next_valid) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pending_q.size() > 0 &&
                         !(pending_q[0].drain_first && verdict_q.size() != 0)) begin
               next_valid = 1'b1;
               next_data  = pending_q[0].req;
            end
         end
      end
      req_if.valid <= next_valid;
      req_if.data  <= next_data;
   end

   // ---------------------------------------------------------------------
   // Monitor. Ready stalls come in random bursts; once, after a few dozen
   // responses, ready stays low for a long stretch so that the response
   // register fills and the block backs up its request side.
   // ---------------------------------------------------------------------
   int  stall_left = 0;
   bit  long_hold_done = 1'b0;

   always @(posedge clock) begin
      logic next_ready;
      next_ready = rsp_if.ready;
      if (!reset) begin
         if (rsp_if.valid && rsp_if.ready) begin
            srlm_tb_pkg::rule_rsp_type got;
            srlm_tb_pkg::rule_rsp_type want;
            got = rsp_if.data;
            received++;
            if (verdict_q.size() == 0) begin
               $display("%0t: response with none expected, actual verdict=%0b status=%0b",
                        $time, got.verdict, got.status);
               errors++;
            end else begin
               want = verdict_q.pop_front();
               if (got.verdict !== want.verdict) begin
                  $display("%0t: verdict mismatch, expected %0b actual %0b",
                           $time, want.verdict, got.verdict);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t: status mismatch, expected %0b actual %0b",
                           $time, want.status, got.status);
                  errors++;
               end
            end
            if (!long_hold_done && received == HOLD_AT_RSP) begin
               long_hold_done = 1'b1;
               stall_left = LONG_HOLD;
            end else if (sent < TOTAL_ITEMS - QUIET_TAIL && $urandom_range(3) == 0) begin
               stall_left = $urandom_range(1, 12);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            next_ready = 1'b0;
         end else begin
            next_ready = 1'b1;
         end
      end else begin
         next_ready = 1'b0;
      end
      rsp_if.ready <= next_ready;
   end

   // ---------------------------------------------------------------------
   // Reset, end of run and the watchdog.
   // ---------------------------------------------------------------------
   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      wait (stimulus_done && pending_q.size() == 0 && verdict_q.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (verdict_q.size() != 0) begin
         $display("%0t: %0d expected responses never arrived", $time, verdict_q.size());
         errors++;
      end
      $display("Ran %0d request transactions: %0d adds (%0d dropped on a full table),",
               sent, n_adds, n_full);
      $display("%0d queries forwarded and %0d denied, %0d mismatches.", n_fwd, n_deny, errors);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // The slowest run is about 1200 transactions plus their stalls; this limit
   // is many times that.
   initial begin
      #(64'd20_000_000 * 20);
      $display("Test completed with failures");
      $finish;
   end

endmodule
